// ----- rtl/pbnk_pkg.sv -----
// ----------------------------------------------------------------------------
// pbnk_pkg
// Shared types, constants and codes of the polar bin nearest-k store.
// ----------------------------------------------------------------------------
`default_nettype none
package pbnk_pkg;
    localparam int SECTIONS_DEF = 8;
    localparam int KEEP_DEF     = 8;
    localparam int RAD_W = 24;
    localparam int TAG_W = 32;
    localparam int CNT_W = 4;

    typedef enum logic [2:0] {
        OP_ADD     = 3'd0,
        OP_POP     = 3'd1,
        OP_GET     = 3'd2,
        OP_QCOUNT  = 3'd3,
        OP_QNEAR   = 3'd4
    } t_op;

    typedef struct packed {
        logic [2:0]       opcode;
        logic [15:0]      angle;
        logic [RAD_W-1:0] radius;
        logic [TAG_W-1:0] point_tag;
    } t_in;

    typedef struct packed {
        logic             valid_point;
        logic [TAG_W-1:0] point_tag_res;
        logic [CNT_W-1:0] bin_count;
        logic [RAD_W-1:0] nearest_radius;
        logic             empty_error;
        logic             last;
    } t_out;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN_RD, S_SCAN, S_SHIFT_POS, S_SHIFT_RD, S_SHIFT_WR, S_PLACE,
        S_EMIT_BIN, S_EMIT_RD, S_EMIT_WAIT, S_EMIT_OUT, S_EMPTY_OUT,
        S_QUERY_RD, S_QUERY_OUT
    } t_state;

    // Kinds of result loaded into the output register.
    typedef enum logic [1:0] {
        K_POINT = 2'd0,
        K_EMPTY = 2'd1,
        K_COUNT = 2'd2,
        K_NEAR  = 2'd3
    } t_kind;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture input transaction and bin
        logic rd_scan;    // read entry at r_idx-1
        logic idx_inc;
        logic idx_dec;
        logic idx_clr;
        logic set_idx_from_fill; // r_pos = r_idx; r_idx = top slot of the shift
        logic wr_shift;   // write held entry to r_idx
        logic wr_place;   // write new point at r_idx
        logic fill_inc;
        logic bin_inc;
        logic bin_clr;
        logic clr_fills;
        logic out_load;
        t_kind out_kind;
    } t_cmd;

    // Status back to the controller.
    typedef struct packed {
        t_op  op;
        logic op_valid;
        logic scan_done;      // idx reached fill
        logic scan_stop;      // new radius below entry read
        logic pos_full;       // insertion position is KEEP
        logic idx_at_pos;
        logic bin_empty;      // emit bin fill is zero
        logic idx_last_in_bin;
        logic any_after;      // any later bin non-empty
        logic any_stored;
        logic out_busy;
    } t_sts;
endpackage
`default_nettype wire

// ----- rtl/polar_bin_nearest_k_store_top.sv -----
// ----------------------------------------------------------------------------
// polar_bin_nearest_k_store_top
// Angular bins of range points, each keeping its nearest KEEP tags in order.
// ----------------------------------------------------------------------------
//  channel | valid      | ready      | payload
//  input   | i_in_valid | o_in_ready | i_in   (t_in)
//  output  | o_out_valid| i_out_ready| o_out  (t_out)
//
// An add scans the bin for the insertion position, shifts the later entries
// up one slot and writes the new point; a point past a full bin is dropped.
// A query returns the bin's count or its nearest radius. Pop and get emit the
// stored tags bin by bin; an empty store answers with an empty result.
// Reset empties every bin at once. A stalled output holds the sequencer in
// the state that loads the next result.
`default_nettype none
module polar_bin_nearest_k_store_top #(
    parameter int SECTIONS = pbnk_pkg::SECTIONS_DEF,
    parameter int KEEP     = pbnk_pkg::KEEP_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire pbnk_pkg::t_in i_in,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output pbnk_pkg::t_out     o_out
);
    import pbnk_pkg::*;
    t_cmd w_cmd;
    t_sts w_sts;

    pbnk_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready), .i_sts(w_sts), .o_cmd(w_cmd)
    );

    pbnk_datapath #(.SECTIONS(SECTIONS), .KEEP(KEEP)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_in), .i_cmd(w_cmd),
        .i_out_ready(i_out_ready), .o_sts(w_sts), .o_out(o_out),
        .o_out_valid(o_out_valid)
    );
endmodule
`default_nettype wire

// ----- rtl/pbnk_ram.sv -----
// ----------------------------------------------------------------------------
// pbnk_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module pbnk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- rtl/pbnk_datapath.sv -----
// ----------------------------------------------------------------------------
// pbnk_datapath
// Holds bin fills, entry memories, scan index and the output register.
// ----------------------------------------------------------------------------
`default_nettype none
module pbnk_datapath #(
    parameter int SECTIONS = pbnk_pkg::SECTIONS_DEF,
    parameter int KEEP     = pbnk_pkg::KEEP_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire pbnk_pkg::t_in  i_in,
    input  wire pbnk_pkg::t_cmd i_cmd,
    input  wire logic           i_out_ready,
    output pbnk_pkg::t_sts      o_sts,
    output pbnk_pkg::t_out      o_out,
    output logic                o_out_valid
);
    import pbnk_pkg::*;
    localparam int BW = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
    localparam int KW = (KEEP > 1) ? $clog2(KEEP) : 1;
    localparam int IW = $clog2(KEEP + 1);
    localparam int FW = $clog2(KEEP + 1);
    localparam int SLOTS = SECTIONS * KEEP;
    localparam int AW = $clog2(SLOTS) > 0 ? $clog2(SLOTS) : 1;
    localparam int MW = $clog2(SECTIONS) + 16 > 16 ? $clog2(SECTIONS) + 16 : 17;

    logic [FW-1:0] r_fill [SECTIONS];
    logic [2:0]       r_op;
    logic [BW-1:0]    r_bin, r_ebin;
    logic [RAD_W-1:0] r_rad;
    logic [TAG_W-1:0] r_tag;
    logic [IW-1:0]    r_idx, r_pos;
    t_out             r_out;
    t_out             n_out;
    logic             r_out_valid;

    logic [MW-1:0]    w_prod;
    logic [BW-1:0]    w_bin;
    logic [RAD_W-1:0] w_rrad;
    logic [TAG_W-1:0] w_rtag;
    logic [AW-1:0]    w_raddr, w_waddr;
    logic [BW-1:0]    w_abin;
    logic             w_we;
    logic [RAD_W-1:0] w_wrad;
    logic [TAG_W-1:0] w_wtag;
    logic [SECTIONS-1:0] w_after;
    logic [IW-1:0]    w_ridx;

    assign w_prod = MW'(i_in.angle) * MW'(SECTIONS);
    always_comb begin
        if (SECTIONS > 1) begin
            w_bin = BW'(w_prod >> 16);
        end else begin
            w_bin = '0;
        end
    end

    // Reads use r_idx, or r_idx-1 while shifting entries up.
    assign w_abin  = (r_op == OP_POP || r_op == OP_GET) ? r_ebin : r_bin;
    assign w_ridx  = i_cmd.rd_scan ? r_idx - IW'(1) : r_idx;
    assign w_raddr = AW'(w_abin) * AW'(KEEP) + AW'(w_ridx[KW-1:0]);
    assign w_waddr = AW'(r_bin) * AW'(KEEP) + AW'(r_idx[KW-1:0]);
    assign w_we    = i_cmd.wr_shift | i_cmd.wr_place;
    assign w_wrad  = i_cmd.wr_place ? r_rad : w_rrad;
    assign w_wtag  = i_cmd.wr_place ? r_tag : w_rtag;

    pbnk_ram #(.WIDTH(RAD_W), .DEPTH(SLOTS)) u_rad (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wrad),
        .i_raddr(w_raddr), .o_rdata(w_rrad)
    );
    pbnk_ram #(.WIDTH(TAG_W), .DEPTH(SLOTS)) u_tag (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wtag),
        .i_raddr(w_raddr), .o_rdata(w_rtag)
    );

    always_comb begin
        for (int b = 0; b < SECTIONS; b++) begin
            w_after[b] = (b > int'(r_ebin)) && (r_fill[b] != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int b = 0; b < SECTIONS; b++) begin
                r_fill[b] <= '0;
            end
            r_out_valid <= 1'b0;
            r_op <= '0;
        end else begin
            if (i_cmd.load) begin
                r_op  <= i_in.opcode;
                r_bin <= w_bin;
                r_rad <= i_in.radius;
                r_tag <= i_in.point_tag;
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.set_idx_from_fill) begin
                r_pos <= r_idx;
                r_idx <= (r_fill[r_bin] == FW'(KEEP)) ? IW'(KEEP - 1) : IW'(r_fill[r_bin]);
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + IW'(1);
            end else if (i_cmd.idx_dec) begin
                r_idx <= r_idx - IW'(1);
            end
            if (i_cmd.bin_clr) begin
                r_ebin <= '0;
            end else if (i_cmd.bin_inc) begin
                r_ebin <= r_ebin + BW'(1);
            end
            if (i_cmd.clr_fills) begin
                for (int b = 0; b < SECTIONS; b++) begin
                    r_fill[b] <= '0;
                end
            end else if (i_cmd.fill_inc && r_fill[r_bin] != FW'(KEEP)) begin
                r_fill[r_bin] <= r_fill[r_bin] + FW'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        n_out = '0;
        unique case (i_cmd.out_kind)
            K_POINT: begin
                n_out.valid_point   = 1'b1;
                n_out.point_tag_res = w_rtag;
                n_out.last = (r_idx == IW'(r_fill[r_ebin]) - IW'(1)) &&
                             (w_after == '0);
            end
            K_EMPTY: n_out.last = 1'b1;
            K_COUNT: begin
                n_out.bin_count = CNT_W'(r_fill[r_bin]);
                n_out.last = 1'b1;
            end
            K_NEAR: begin
                if (r_fill[r_bin] == '0) begin
                    n_out.empty_error = 1'b1;
                end else begin
                    n_out.nearest_radius = w_rrad;
                end
                n_out.last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= n_out;
        end
    end

    always_comb begin
        o_sts.op        = t_op'(r_op);
        o_sts.op_valid  = (i_in.opcode <= OP_QNEAR);
        o_sts.scan_done = (r_idx == IW'(r_fill[r_bin]));
        o_sts.scan_stop = (r_rad < w_rrad);
        o_sts.pos_full  = (r_idx == IW'(KEEP));
        o_sts.idx_at_pos = (r_idx == r_pos);
        o_sts.bin_empty = (r_fill[r_ebin] == '0);
        o_sts.idx_last_in_bin = (r_idx == IW'(r_fill[r_ebin]) - IW'(1));
        o_sts.any_after = (w_after != '0);
        o_sts.any_stored = 1'b0;
        for (int b = 0; b < SECTIONS; b++) begin
            o_sts.any_stored = o_sts.any_stored | (r_fill[b] != '0);
        end
        o_sts.out_busy  = r_out_valid && !i_out_ready;
    end

    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;
endmodule
`default_nettype wire

// ----- rtl/pbnk_ctrl.sv -----
// ----------------------------------------------------------------------------
// pbnk_ctrl
// Sequences insert scans, emission sweeps and queries.
// ----------------------------------------------------------------------------
`default_nettype none
module pbnk_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    input  wire pbnk_pkg::t_sts i_sts,
    output pbnk_pkg::t_cmd      o_cmd
);
    import pbnk_pkg::*;
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid && i_sts.op_valid) begin
                    o_cmd.load = 1'b1;
                    o_cmd.idx_clr = 1'b1;
                    o_cmd.bin_clr = 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                unique case (i_sts.op) inside
                    OP_ADD: begin
                        n_state = i_sts.scan_done ? S_SHIFT_POS : S_SCAN;
                    end
                    OP_POP, OP_GET: begin
                        n_state = i_sts.any_stored ? S_EMIT_BIN : S_EMPTY_OUT;
                    end
                    default: n_state = S_QUERY_RD;
                endcase
            end
            S_SCAN: begin
                if (i_sts.scan_stop) begin
                    n_state = S_SHIFT_POS;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state = S_SCAN_RD;
                end
            end
            S_SHIFT_POS: begin
                if (i_sts.pos_full) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.set_idx_from_fill = 1'b1;
                    n_state = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD: begin
                if (i_sts.idx_at_pos) begin
                    n_state = S_PLACE;
                end else begin
                    o_cmd.rd_scan = 1'b1;
                    n_state = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.idx_dec = 1'b1;
                n_state = S_SHIFT_RD;
            end
            S_PLACE: begin
                o_cmd.wr_place = 1'b1;
                o_cmd.fill_inc = 1'b1;
                n_state = S_IDLE;
            end
            S_EMIT_BIN: begin
                o_cmd.idx_clr = 1'b1;
                if (i_sts.bin_empty) begin
                    o_cmd.bin_inc = 1'b1;
                end else begin
                    n_state = S_EMIT_RD;
                end
            end
            S_EMIT_RD: n_state = S_EMIT_WAIT;
            S_EMIT_WAIT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = K_POINT;
                    if (!i_sts.idx_last_in_bin) begin
                        o_cmd.idx_inc = 1'b1;
                        n_state = S_EMIT_RD;
                    end else if (i_sts.any_after) begin
                        o_cmd.bin_inc = 1'b1;
                        n_state = S_EMIT_BIN;
                    end else begin
                        o_cmd.clr_fills = (i_sts.op == OP_POP);
                        n_state = S_IDLE;
                    end
                end
            end
            S_EMPTY_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = K_EMPTY;
                    n_state = S_IDLE;
                end
            end
            S_QUERY_RD: n_state = S_QUERY_OUT;
            S_QUERY_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_kind = (i_sts.op == OP_QCOUNT) ? K_COUNT : K_NEAR;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire
